// ===== hw/rtl/pipt_pkg.sv =====
package pipt_pkg;

    // Fixed widths of the port fields
    localparam int REQ_W        = 2;
    localparam int PORT_COORD_W = 32;
    localparam int COUNT_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request codes carried on req_type
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_DIFF,
        ST_MUL1,
        ST_MUL2,
        ST_CMP,
        ST_FINISH
    } seq_state_t;

    // Strobes from the sequencer to the edge arithmetic
    typedef struct packed {
        logic start;   // clear the inside flag for a new query
        logic load;    // latch edge differences
        logic mul_ad;  // first product
        logic mul_bc;  // second product, keep the first
        logic check;   // compare products and toggle
    } cross_ctrl_t;

endpackage

// ===== hw/rtl/point_in_polygon_test.sv =====
// Even-odd ray-casting point-in-polygon tester.
//
// Input channel (s_valid/s_ready): one word per request. req_type clear
// empties the polygon, zeroes the inside count and the truncation flag;
// append stores one vertex (dropped, and the sticky truncation flag set,
// once MAX_VERTICES are held); query tests a point. Clear, append and the
// unused code give no result word.
// Result channel (m_valid/m_ready): one word per query carrying the inside
// flag, the saturating inside count of the batch and the truncation flag.
// last_in_batch on a query zeroes the count after that result.
//
// A query walks every stored edge through one shared multiplier: an edge
// that does not straddle the point's longitude takes only the difference
// step, one that does takes difference, two products and compare. A vertex
// store fetch comes before the walk and a finish step after it; s_ready
// stays low meanwhile. An empty polygon goes straight to the finish step.
// The result sits in an output register: a stalled receiver holds it, and
// the tester returns to idle as soon as the word is parked, stalling only
// when a second query finishes before the first word is taken. Reset
// (aresetn low, synchronous) empties the polygon and clears the count,
// flags and result valid; the vertex store itself is not cleared.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pipt_pkg::REQ_W-1:0]        s_req_type,
    input  logic signed [pipt_pkg::PORT_COORD_W-1:0] s_coord_lat,
    input  logic signed [pipt_pkg::PORT_COORD_W-1:0] s_coord_lon,
    input  logic                              s_last_in_batch,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_res,
    output logic [pipt_pkg::COUNT_W-1:0]      m_inside_count,
    output logic                              m_polygon_truncated
);

    localparam int CW = COORD_BITS;
    localparam int PW = pipt_pkg::PORT_COORD_W;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int TW = $clog2(MAX_VERTICES + 1);

    pipt_pkg::seq_state_t state_reg, state_next;

    // Vertex store: {lat, lon} per entry
    logic [2*CW-1:0] vtx_mem [MAX_VERTICES];
    logic [2*CW-1:0] mem_q_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic [TW-1:0]   total_reg;
    logic [TW-1:0]   total_m1;
    logic [AW-1:0]   idx_reg;
    logic            edge_last;
    logic            edge_last_reg;
    logic [pipt_pkg::COUNT_W-1:0] cnt_reg;
    logic [pipt_pkg::COUNT_W-1:0] cnt_new;
    logic            trunc_reg;

    logic [CW-1:0]   pt_lat_reg, pt_lon_reg;
    logic [CW-1:0]   prv_lat_reg, prv_lon_reg;
    logic            last_reg;

    logic [CW+PW-1:0] lat_ext, lon_ext;
    logic [CW-1:0]    in_lat, in_lon;

    logic            s_fire;
    logic            is_query;
    logic            out_load;
    logic            straddle;
    logic            in_poly;
    pipt_pkg::cross_ctrl_t ctrl;

    logic            m_valid_reg;
    logic            m_inside_res_reg;
    logic [pipt_pkg::COUNT_W-1:0] m_inside_count_reg;
    logic            m_polygon_truncated_reg;

    // Take the low COORD_BITS of the port value, sign-extending when wider
    assign lat_ext = {{CW{s_coord_lat[PW-1]}}, s_coord_lat};
    assign lon_ext = {{CW{s_coord_lon[PW-1]}}, s_coord_lon};
    assign in_lat  = lat_ext[CW-1:0];
    assign in_lon  = lon_ext[CW-1:0];

    assign s_fire    = s_valid && s_ready;
    assign is_query  = (s_req_type == pipt_pkg::REQ_QUERY);
    assign total_m1  = total_reg - 1'b1;
    assign edge_last = (idx_reg == total_m1[AW-1:0]);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pipt_pkg::ST_IDLE: begin
                if (s_valid && is_query) begin
                    if (total_reg == '0) begin
                        state_next = pipt_pkg::ST_FINISH;
                    end else begin
                        state_next = pipt_pkg::ST_PRIME;
                    end
                end
            end
            pipt_pkg::ST_PRIME: begin
                state_next = pipt_pkg::ST_DIFF;
            end
            pipt_pkg::ST_DIFF: begin
                if (straddle) begin
                    state_next = pipt_pkg::ST_MUL1;
                end else if (edge_last) begin
                    state_next = pipt_pkg::ST_FINISH;
                end
            end
            pipt_pkg::ST_MUL1: begin
                state_next = pipt_pkg::ST_MUL2;
            end
            pipt_pkg::ST_MUL2: begin
                state_next = pipt_pkg::ST_CMP;
            end
            pipt_pkg::ST_CMP: begin
                if (edge_last_reg) begin
                    state_next = pipt_pkg::ST_FINISH;
                end else begin
                    state_next = pipt_pkg::ST_DIFF;
                end
            end
            pipt_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pipt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pipt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = idx_reg + 1'b1;
        out_load = 1'b0;
        ctrl     = '0;
        case (state_reg)
            pipt_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                rd_addr    = total_m1[AW-1:0];
                rd_en      = s_valid && is_query && (total_reg != '0);
                ctrl.start = s_valid && is_query;
            end
            pipt_pkg::ST_PRIME: begin
                rd_addr = idx_reg;
                rd_en   = 1'b1;
            end
            pipt_pkg::ST_DIFF: begin
                rd_en     = !edge_last;
                ctrl.load = 1'b1;
            end
            pipt_pkg::ST_MUL1: begin
                ctrl.mul_ad = 1'b1;
            end
            pipt_pkg::ST_MUL2: begin
                ctrl.mul_bc = 1'b1;
            end
            pipt_pkg::ST_CMP: begin
                ctrl.check = 1'b1;
            end
            pipt_pkg::ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Vertex store access
    always_ff @(posedge aclk) begin
        if (s_fire && (s_req_type == pipt_pkg::REQ_APPEND)
                && (total_reg < TW'(MAX_VERTICES))) begin
            vtx_mem[total_reg[AW-1:0]] <= {in_lat, in_lon};
        end
        if (rd_en) begin
            mem_q_reg <= vtx_mem[rd_addr];
        end
    end

    // Query walk registers
    always_ff @(posedge aclk) begin
        if (s_fire && is_query) begin
            pt_lat_reg <= in_lat;
            pt_lon_reg <= in_lon;
            last_reg   <= s_last_in_batch;
            idx_reg    <= '0;
        end
        // Hold the previous vertex of the edge
        if (state_reg == pipt_pkg::ST_PRIME || state_reg == pipt_pkg::ST_DIFF) begin
            prv_lat_reg <= mem_q_reg[2*CW-1:CW];
            prv_lon_reg <= mem_q_reg[CW-1:0];
        end
        if (state_reg == pipt_pkg::ST_DIFF) begin
            edge_last_reg <= edge_last;
            idx_reg       <= idx_reg + 1'b1;
        end
    end

    // Saturate the count, then apply the batch boundary
    assign cnt_new = (in_poly && (cnt_reg != pipt_pkg::COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pipt_pkg::ST_IDLE;
            total_reg   <= '0;
            cnt_reg     <= '0;
            trunc_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire && (s_req_type == pipt_pkg::REQ_CLEAR)) begin
                total_reg <= '0;
                cnt_reg   <= '0;
                trunc_reg <= 1'b0;
            end else if (s_fire && (s_req_type == pipt_pkg::REQ_APPEND)) begin
                if (total_reg < TW'(MAX_VERTICES)) begin
                    total_reg <= total_reg + 1'b1;
                end else begin
                    trunc_reg <= 1'b1;
                end
            end
            if (out_load) begin
                cnt_reg     <= last_reg ? '0 : cnt_new;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_inside_res_reg        <= in_poly;
            m_inside_count_reg      <= cnt_new;
            m_polygon_truncated_reg <= trunc_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_inside_res        = m_inside_res_reg;
    assign m_inside_count      = m_inside_count_reg;
    assign m_polygon_truncated = m_polygon_truncated_reg;

    pipt_cross_unit #(
        .CW (CW)
    ) u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .pt_lat   (pt_lat_reg),
        .pt_lon   (pt_lon_reg),
        .cur_lat  (mem_q_reg[2*CW-1:CW]),
        .cur_lon  (mem_q_reg[CW-1:0]),
        .prv_lat  (prv_lat_reg),
        .prv_lon  (prv_lon_reg),
        .straddle (straddle),
        .in_poly  (in_poly)
    );

    // The vertex count never passes the store depth
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // Truncation is only raised by an append to a full store
    a_trunc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(trunc_reg) |-> total_reg == TW'(MAX_VERTICES))
        else $error("truncation flag set with room left");

    // An inside result always carries a nonzero count
    a_inside_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_res |-> m_inside_count != '0)
        else $error("inside result with zero count");

    // Products are only formed right after an edge was found to straddle
    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pipt_pkg::ST_MUL1 |-> $past(state_reg) == pipt_pkg::ST_DIFF && $past(straddle))
        else $error("multiply pass without straddling edge");

endmodule

// ===== hw/rtl/pipt_cross_unit.sv =====
module pipt_cross_unit #(
    parameter int CW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pipt_pkg::cross_ctrl_t ctrl,
    input  logic [CW-1:0]         pt_lat,
    input  logic [CW-1:0]         pt_lon,
    input  logic [CW-1:0]         cur_lat,
    input  logic [CW-1:0]         cur_lon,
    input  logic [CW-1:0]         prv_lat,
    input  logic [CW-1:0]         prv_lon,
    output logic                  straddle,
    output logic                  in_poly
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] px, py, xi, yi, xj, yj;
    logic signed [DW-1:0] a_next, b_next, c_next, d_next, c_raw, d_raw;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [DW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] prod, prod_reg, lhs_reg;
    logic                 inside_reg;

    assign px = $signed({pt_lat[CW-1], pt_lat});
    assign py = $signed({pt_lon[CW-1], pt_lon});
    assign xi = $signed({cur_lat[CW-1], cur_lat});
    assign yi = $signed({cur_lon[CW-1], cur_lon});
    assign xj = $signed({prv_lat[CW-1], prv_lat});
    assign yj = $signed({prv_lon[CW-1], prv_lon});

    // Edge spans the query longitude
    assign straddle = (yi > py) != (yj > py);

    // Flip both sides when the longitude span is negative
    always_comb begin
        a_next = px - xi;
        b_next = xj - xi;
        c_raw  = py - yi;
        d_raw  = yj - yi;
        if (d_raw[DW-1]) begin
            c_next = -c_raw;
            d_next = -d_raw;
        end else begin
            c_next = c_raw;
            d_next = d_raw;
        end
    end

    // One shared multiplier, two passes per straddling edge
    assign mul_x = ctrl.mul_ad ? a_reg : b_reg;
    assign mul_y = ctrl.mul_ad ? d_reg : c_reg;
    assign prod  = PW'(mul_x) * PW'(mul_y);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
        if (ctrl.mul_ad || ctrl.mul_bc) begin
            prod_reg <= prod;
        end
        if (ctrl.mul_bc) begin
            lhs_reg <= prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
        end else if (ctrl.start) begin
            inside_reg <= 1'b0;
        end else if (ctrl.check && (lhs_reg < prod_reg)) begin
            inside_reg <= ~inside_reg;
        end
    end

    assign in_poly = inside_reg;

endmodule

// ===== verif/tb_point_in_polygon_test.sv =====
module tb_point_in_polygon_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration under test
    localparam int MAX_VERTS = 1024;
    localparam int CRD_BITS  = 32;

    typedef logic [pipt_pkg::REQ_W-1:0]   req_t;
    typedef logic [pipt_pkg::COUNT_W-1:0] count_t;

    // Code with no request behind it; the block must swallow it silently
    localparam req_t REQ_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 580;
    localparam int LONG_HOLD    = 400;    // receiver stall that backs up the block
    localparam int STALL_LIMIT  = 20000;  // watchdog limit on quiet cycles, with room for a full-store query
    localparam int END_SETTLE   = 16;

    typedef logic signed [pipt_pkg::PORT_COORD_W-1:0] coord_t;

    localparam coord_t C_MIN = coord_t'(32'h8000_0000);
    localparam coord_t C_MAX = coord_t'(32'h7fff_ffff);

    // One expected result word
    typedef struct {
        logic   in_poly;
        count_t count;
        logic   truncated;
    } answer_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    req_t                     s_req_type;
    coord_t                   s_coord_lat;
    coord_t                   s_coord_lon;
    logic                     s_last_in_batch;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_inside_res;
    count_t                   m_inside_count;
    logic                     m_polygon_truncated;

    // Shadow polygon, batch count and truncation flag
    coord_t             poly_lat [MAX_VERTS];
    coord_t             poly_lon [MAX_VERTS];
    int unsigned        poly_total  = 0;
    count_t             batch_count = '0;
    logic               poly_trunc  = 1'b0;
    answer_t            expected_answers[$];

    // Traffic shaping shared between the stimulus and the result sink
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned holds_asked  = 0;
    int unsigned holds_served = 0;

    // Run statistics
    int unsigned words_sent = 0;
    int unsigned n_clear    = 0;
    int unsigned n_append   = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_unused   = 0;
    int unsigned n_query    = 0;
    int unsigned n_inside   = 0;
    int unsigned n_checked  = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERTS),
        .COORD_BITS   (CRD_BITS)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_coord_lat         (s_coord_lat),
        .s_coord_lon         (s_coord_lon),
        .s_last_in_batch     (s_last_in_batch),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_inside_res        (m_inside_res),
        .m_inside_count      (m_inside_count),
        .m_polygon_truncated (m_polygon_truncated)
    );

    // Even-odd ray cast over the shadow polygon. Edge (i, j) toggles when it
    // straddles the point's longitude and the point lies on the low side of
    // the edge. The slope division is replaced by a cross product whose sense
    // is fixed by flipping both terms when the edge's longitude span is
    // negative; all products are exact at 128 bits.
    function automatic logic point_is_inside(coord_t plat, coord_t plon);
        logic                  flag;
        int unsigned           j;
        logic signed [63:0]    a, b, c, d;
        logic signed [127:0]   lhs, rhs;
        flag = 1'b0;
        if (poly_total == 0) return 1'b0;
        j = poly_total - 1;
        for (int unsigned i = 0; i < poly_total; i++) begin
            // a horizontal edge never passes this test, so it never toggles
            if ((poly_lon[i] > plon) != (poly_lon[j] > plon)) begin
                a = 64'(plat) - 64'(poly_lat[i]);
                b = 64'(poly_lat[j]) - 64'(poly_lat[i]);
                c = 64'(plon) - 64'(poly_lon[i]);
                d = 64'(poly_lon[j]) - 64'(poly_lon[i]);
                if (d < 0) begin
                    d = -d;
                    c = -c;
                end
                lhs = 128'(a) * 128'(d);
                rhs = 128'(b) * 128'(c);
                if (lhs < rhs) flag = !flag;
            end
            j = i;
        end
        return flag;
    endfunction

    // Advance the shadow state by one accepted word; queue the answer of a query
    function automatic void apply_request(req_t req, coord_t lat, coord_t lon, logic last);
        answer_t ans;
        logic    hit;
        case (req)
            pipt_pkg::REQ_CLEAR: begin
                poly_total  = 0;
                batch_count = '0;
                poly_trunc  = 1'b0;
                n_clear++;
            end
            pipt_pkg::REQ_APPEND: begin
                n_append++;
                if (poly_total < MAX_VERTS) begin
                    poly_lat[poly_total] = lat;
                    poly_lon[poly_total] = lon;
                    poly_total++;
                end else begin
                    // store full: drop the vertex, remember it
                    poly_trunc = 1'b1;
                    n_dropped++;
                end
            end
            pipt_pkg::REQ_QUERY: begin
                hit = point_is_inside(lat, lon);
                if (hit && batch_count != pipt_pkg::COUNT_MAX) batch_count++;
                ans.in_poly   = hit;
                ans.count     = batch_count;
                ans.truncated = poly_trunc;
                expected_answers.push_back(ans);
                // end of batch: the count restarts after this answer
                if (last) batch_count = '0;
                n_query++;
                if (hit) n_inside++;
            end
            default: n_unused++;
        endcase
    endfunction

    // Offer one word after a random gap; hold it until the block takes it.
    // Valid is only lowered when a gap is drawn, so back-to-back words keep
    // valid high across the boundary.
    task automatic send_request(req_t req, coord_t lat, coord_t lon, logic last);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_coord_lat     <= lat;
        s_coord_lon     <= lon;
        s_last_in_batch <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(req, lat, lon, last);
        words_sent++;
    endtask

    // Drop valid and wait until every queued answer has come back
    task automatic drain_answers();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_answers.size() != 0) @(posedge aclk);
    endtask

    // Random point within 2**span of base; callers keep base and span small
    // enough that the sum cannot wrap.
    function automatic coord_t coord_near(coord_t base, int unsigned span);
        longint off;
        off = longint'($urandom_range(0, 32'd1 << (span + 1))) - (longint'(1) << span);
        return coord_t'(longint'(base) + off);
    endfunction

    // Queries against an empty store, the unused code, and a clear
    task automatic test_empty_polygon();
        send_request(pipt_pkg::REQ_QUERY, C_MAX, C_MIN, 1'b1);
        send_request(REQ_UNUSED, C_MIN, C_MAX, 1'b1);
        send_request(pipt_pkg::REQ_CLEAR, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b0);
        drain_answers();
    endtask

    // One- and two-vertex polygons: walked as usual, never enclose anything
    task automatic test_degenerate_polygon();
        send_request(pipt_pkg::REQ_CLEAR, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(5), coord_t'(5), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(5), coord_t'(5), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(100), coord_t'(-100), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(50), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(200), coord_t'(0), 1'b1);
        drain_answers();
    endtask

    // Square spanning the whole coordinate range. Its top and bottom edges
    // have equal longitudes, so points on those longitudes hit the
    // horizontal-edge rule; corner points push the products to their limits.
    task automatic test_extreme_square();
        send_request(pipt_pkg::REQ_CLEAR, C_MAX, C_MIN, 1'b1);
        send_request(pipt_pkg::REQ_APPEND, C_MIN, C_MIN, 1'b0);
        send_request(pipt_pkg::REQ_APPEND, C_MAX, C_MIN, 1'b0);
        send_request(pipt_pkg::REQ_APPEND, C_MAX, C_MAX, 1'b0);
        send_request(pipt_pkg::REQ_APPEND, C_MIN, C_MAX, 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(-1), coord_t'(-1), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, C_MIN, C_MIN, 1'b0);
        send_request(pipt_pkg::REQ_QUERY, C_MAX, C_MAX, 1'b0);
        send_request(pipt_pkg::REQ_QUERY, C_MAX, coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), C_MAX, 1'b1);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(5), coord_t'(5), 1'b0);
        drain_answers();
    endtask

    // Fill the store past its depth, query the full polygon, then clear
    task automatic test_store_overflow();
        send_request(pipt_pkg::REQ_CLEAR, coord_t'(0), coord_t'(0), 1'b0);
        for (int k = 0; k < MAX_VERTS + 3; k++) begin
            send_request(pipt_pkg::REQ_APPEND, coord_t'($urandom), coord_t'($urandom),
                         1'($urandom));
        end
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'($urandom), coord_t'($urandom), 1'b1);
        // clear must also drop the sticky flag
        send_request(pipt_pkg::REQ_CLEAR, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b1);
        drain_answers();
    endtask

    // Park the receiver for a long stretch while queries keep coming, so the
    // output register and the sequencer fill and s_ready drops; then pause
    // the sender until every answer is home.
    task automatic test_output_backpressure();
        send_request(pipt_pkg::REQ_CLEAR, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(-1000), coord_t'(-1000), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(1000), coord_t'(-1000), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(1000), coord_t'(1000), 1'b0);
        send_request(pipt_pkg::REQ_APPEND, coord_t'(-1000), coord_t'(1000), 1'b0);
        tx_idle_on = 1'b0;
        holds_asked++;
        for (int k = 0; k < 8; k++) begin
            send_request(pipt_pkg::REQ_QUERY, coord_near(coord_t'(0), 11),
                         coord_near(coord_t'(0), 11), k == 7);
        end
        drain_answers();
        send_request(pipt_pkg::REQ_QUERY, coord_t'(0), coord_t'(0), 1'b0);
        send_request(pipt_pkg::REQ_QUERY, coord_t'(999), coord_t'(-999), 1'b1);
        drain_answers();
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed batches: clear, a small random polygon, then a run
    // of queries around it. Some batches skip the clear or use one or two
    // vertices; the rest of the traffic is raw noise on every field.
    task automatic test_random_traffic();
        int unsigned sent_here, n_verts, n_pts, shift, qspan;
        coord_t      c_lat, c_lon, v_lat, v_lon, p_lat, p_lon;
        logic        wide;
        sent_here = 0;
        while (sent_here < RANDOM_WORDS) begin
            // toggle idling per batch so some batches run at full rate
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(req_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                                 1'($urandom));
                    sent_here++;
                end
            end else begin
                wide  = ($urandom_range(0, 7) == 0);
                shift = $urandom_range(2, 28);
                qspan = shift + 1;
                c_lat = coord_t'($signed($urandom) >>> 2);
                c_lon = coord_t'($signed($urandom) >>> 2);
                if ($urandom_range(0, 7) != 0) begin
                    send_request(pipt_pkg::REQ_CLEAR, coord_t'($urandom), coord_t'($urandom),
                                 1'($urandom));
                    sent_here++;
                end
                n_verts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(3, 10);
                v_lon = c_lon;
                for (int unsigned k = 0; k < n_verts; k++) begin
                    v_lat = wide ? coord_t'($urandom) : coord_near(c_lat, shift);
                    // reuse the previous longitude now and then for flat edges
                    if (k == 0 || $urandom_range(0, 4) != 0)
                        v_lon = wide ? coord_t'($urandom) : coord_near(c_lon, shift);
                    send_request(pipt_pkg::REQ_APPEND, v_lat, v_lon, 1'($urandom));
                    sent_here++;
                end
                n_pts = $urandom_range(2, 12);
                for (int unsigned k = 0; k < n_pts; k++) begin
                    p_lat = wide ? coord_t'($urandom) : coord_near(c_lat, qspan);
                    p_lon = wide ? coord_t'($urandom) : coord_near(c_lon, qspan);
                    // land on a vertex's longitude or latitude sometimes
                    if (poly_total != 0 && $urandom_range(0, 4) == 0)
                        p_lon = poly_lon[$urandom_range(0, poly_total - 1)];
                    if (poly_total != 0 && $urandom_range(0, 6) == 0)
                        p_lat = poly_lat[$urandom_range(0, poly_total - 1)];
                    send_request(pipt_pkg::REQ_QUERY, p_lat, p_lon, $urandom_range(0, 4) == 0);
                    sent_here++;
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result sink: take one word, draw a wait, then raise ready again.
    // m_ready gets exactly one assignment per clock.
    initial begin : result_sink
        int unsigned rx_wait;
        answer_t     want;
        rx_wait = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    $error("result word arrived with no query outstanding");
                end else begin
                    want = expected_answers.pop_front();
                    n_checked++;
                    if (m_inside_res !== want.in_poly) begin
                        mismatches++;
                        $error("inside_res: expected %0d, got %0d", want.in_poly,
                               m_inside_res);
                    end
                    if (m_inside_count !== want.count) begin
                        mismatches++;
                        $error("inside_count: expected %0d, got %0d", want.count,
                               m_inside_count);
                    end
                    if (m_polygon_truncated !== want.truncated) begin
                        mismatches++;
                        $error("polygon_truncated: expected %0d, got %0d", want.truncated,
                               m_polygon_truncated);
                    end
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
            end
            // long hold requested by a test: count it out here
            if (holds_served != holds_asked) begin
                holds_served++;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_req_type      <= pipt_pkg::REQ_CLEAR;
        s_coord_lat     <= '0;
        s_coord_lon     <= '0;
        s_last_in_batch <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_polygon();
        test_degenerate_polygon();
        test_extreme_square();
        test_store_overflow();
        test_output_backpressure();
        test_random_traffic();

        // Let the last answers land, then watch for stray words
        drain_answers();
        repeat (END_SETTLE) @(posedge aclk);

        $display("run: %0d words - %0d clears, %0d appends (%0d dropped on a full store), %0d unused",
                 words_sent, n_clear, n_append, n_dropped, n_unused);
        $display("run: %0d queries, %0d inside, %0d result words checked, %0d mismatches",
                 n_query, n_inside, n_checked, mismatches);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
